// ===== hdl/assert_macros.svh =====
// Assertion macros for the top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define LRF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that an antecedent is followed in the same cycle by a consequent.
`define LRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrf_pkg.sv =====
// Types, codes and constants of the line fit block.
package lrf_pkg;

    localparam int MAX_PAIRS_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RES_W           = 32;
    localparam int CORR_W          = 16;
    localparam int CORR_FRAC       = 14;

    typedef enum logic [1:0] {
        FIT_OK,
        FIT_XVAR0,
        FIT_YVAR0,
        FIT_EMPTY
    } t_fit_status;

    typedef enum logic [3:0] {
        MUL_NXX,
        MUL_XX,
        MUL_NYY,
        MUL_YY,
        MUL_NXY,
        MUL_XY,
        MUL_YDXX,
        MUL_DXYX,
        MUL_NDXX,
        MUL_DXXDYY
    } t_mul_op;

    typedef enum logic [1:0] {
        DIV_SLOPE,
        DIV_ICPT,
        DIV_CORR
    } t_div_op;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_DRAIN,
        ST_MUL,
        ST_MUL_W,
        ST_CHECK,
        ST_DIV,
        ST_DIV_W,
        ST_SQRT,
        ST_SQRT_W,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        acc_clr;
        logic        res_clr;
        logic        mul_start;
        t_mul_op     mul_op;
        logic        mul_wr;
        logic        div_start;
        t_div_op     div_op;
        logic        div_wr;
        logic        sqrt_start;
        logic        sqrt_wr;
        logic        stat_wr;
        t_fit_status stat_code;
        logic        out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic n_zero;
        logic dxx_zero;
        logic dyy_zero;
        logic s_zero;
        logic out_full;
    } t_status;

endpackage

// ===== hdl/lrf_if.sv =====
// Request channels of the line fit block: sample pairs in, fit results out.
interface lrf_in_if #(
    parameter int SB = lrf_pkg::SAMPLE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] x_sample;
    logic signed [SB-1:0] y_sample;
    logic                 last_pair;

    modport source (output valid, x_sample, y_sample, last_pair, input ready);
    modport sink   (input valid, x_sample, y_sample, last_pair, output ready);
endinterface

interface lrf_out_if #(
    parameter int CW = $clog2(lrf_pkg::MAX_PAIRS_DEF + 1)
);
    logic                               valid;
    logic                               ready;
    logic signed [lrf_pkg::RES_W-1:0]   slope;
    logic signed [lrf_pkg::RES_W-1:0]   intercept;
    logic signed [lrf_pkg::CORR_W-1:0]  correlation;
    logic        [CW-1:0]               pair_count;
    logic        [1:0]                  fit_status;

    modport source (output valid, slope, intercept, correlation, pair_count, fit_status,
                    input ready);
    modport sink   (input valid, slope, intercept, correlation, pair_count, fit_status,
                    output ready);
endinterface

// ===== hdl/lrf_mul.sv =====
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module lrf_mul #(
    parameter int DW = 66
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [DW-1:0]   i_a,
    input  logic signed [DW-1:0]   i_b,
    output logic                   o_done,
    output logic signed [2*DW-1:0] o_p
);
    localparam int PW  = 2 * DW;
    localparam int CTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_fix;
    logic            r_done;
    logic [CTW-1:0]  r_cnt;
    logic            r_neg;
    logic [PW-1:0]   r_mc;
    logic [DW-1:0]   r_mp;
    logic [PW-1:0]   r_acc;
    logic [DW-1:0]   w_am;
    logic [DW-1:0]   w_bm;

    // take operand magnitudes
    assign w_am = i_a[DW-1] ? DW'(~i_a + 1'b1) : DW'(i_a);
    assign w_bm = i_b[DW-1] ? DW'(~i_b + 1'b1) : DW'(i_b);

    // iterate over multiplier bits, then apply the sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_mc   <= {{DW{1'b0}}, w_am};
                r_mp   <= w_bm;
                r_neg  <= i_a[DW-1] ^ i_b[DW-1];
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= {r_mc[PW-2:0], 1'b0};
                r_mp  <= {1'b0, r_mp[DW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                if (r_neg) begin
                    r_acc <= ~r_acc + 1'b1;
                end
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = $signed(r_acc);
endmodule

// ===== hdl/lrf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lrf_div #(
    parameter int PW = 132
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_num,
    input  logic [PW-1:0] i_den,
    output logic          o_done,
    output logic [PW-1:0] o_q
);
    localparam int CTW = $clog2(PW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CTW-1:0]  r_cnt;
    logic [PW-1:0]   r_q;
    logic [PW-1:0]   r_rem;
    logic [PW-1:0]   r_d;
    logic [PW:0]     w_t;
    logic [PW+1:0]   w_diff;
    logic            w_ge;

    // trial subtract of the shifted remainder
    assign w_t    = {r_rem, r_q[PW-1]};
    assign w_diff = {1'b0, w_t} - {2'b00, r_d};
    assign w_ge   = !w_diff[PW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_d    <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[PW-1:0] : w_t[PW-1:0];
                r_q   <= {r_q[PW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CTW'(PW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== hdl/lrf_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module lrf_sqrt #(
    parameter int PW = 132
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PW-1:0]   i_v,
    output logic            o_done,
    output logic [PW/2-1:0] o_root
);
    localparam int HW  = PW / 2;
    localparam int RW  = HW + 3;
    localparam int CTW = $clog2(HW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CTW-1:0]  r_cnt;
    logic [PW-1:0]   r_v;
    logic [HW-1:0]   r_root;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   w_t;
    logic [RW-1:0]   w_trial;
    logic [RW:0]     w_diff;
    logic            w_ge;

    // bring down two bits, try root*4+1
    assign w_t     = {r_rem[RW-3:0], r_v[PW-1:PW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_diff  = {1'b0, w_t} - {1'b0, w_trial};
    assign w_ge    = !w_diff[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_v;
                r_root <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[RW-1:0] : w_t;
                r_root <= {r_root[HW-2:0], w_ge};
                r_v    <= {r_v[PW-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CTW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== hdl/lrf_dp.sv =====
// Datapath: sums, fit registers, arithmetic units and result register.
module lrf_dp #(
    parameter int MAX_PAIRS   = lrf_pkg::MAX_PAIRS_DEF,
    parameter int SAMPLE_BITS = lrf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic signed [SAMPLE_BITS-1:0]      i_x,
    input  logic signed [SAMPLE_BITS-1:0]      i_y,
    input  lrf_pkg::t_cmd                      i_cmd,
    output lrf_pkg::t_status                   o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [lrf_pkg::RES_W-1:0]   o_slope,
    output logic signed [lrf_pkg::RES_W-1:0]   o_icpt,
    output logic signed [lrf_pkg::CORR_W-1:0]  o_corr,
    output logic [$clog2(MAX_PAIRS+1)-1:0]     o_count,
    output logic [1:0]                         o_stat
);
    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int SW1 = SB + CW;
    localparam int SW2 = 2 * SB + CW;
    localparam int DW  = 2 * SB + 2 * CW;
    localparam int PW  = 2 * DW;
    localparam int RW  = lrf_pkg::RES_W;
    localparam int KW  = lrf_pkg::CORR_W;

    localparam logic [RW-1:0] POS_MAX  = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_MAX  = {1'b1, {(RW-1){1'b0}}};
    localparam logic [KW-1:0] CORR_ONE = KW'(1) << lrf_pkg::CORR_FRAC;

    // product stage and accumulators
    logic                    r_p_vld;
    logic signed [2*SB-1:0]  r_pxx, r_pyy, r_pxy;
    logic signed [SB-1:0]    r_px, r_py;
    logic [CW-1:0]           r_cnt;
    logic signed [SW1-1:0]   r_sx, r_sy;
    logic signed [SW2-1:0]   r_sxx, r_syy, r_sxy;

    // fit registers
    logic signed [DW-1:0]    r_dxx, r_dyy, r_dxy;
    logic signed [PW-1:0]    r_inum;
    logic [PW-1:0]           r_den;
    logic [PW-1:0]           r_prod;
    logic [DW-1:0]           r_s;

    // results
    logic [RW-1:0]           r_slope, r_icpt;
    logic [KW-1:0]           r_corr;
    lrf_pkg::t_fit_status    r_stat;
    logic                    r_ovld;
    logic [RW-1:0]           r_o_slope, r_o_icpt;
    logic [KW-1:0]           r_o_corr;
    logic [CW-1:0]           r_o_count;
    logic [1:0]              r_o_stat;

    // unit connections
    logic signed [DW-1:0]    w_ma, w_mb;
    logic signed [PW-1:0]    w_p;
    logic                    w_mdone;
    logic [PW-1:0]           w_dnum, w_dden, w_q;
    logic                    w_ddone;
    logic [DW-1:0]           w_root;
    logic                    w_sdone;
    logic [DW-1:0]           w_adxy;
    logic [PW-1:0]           w_adxy_p, w_ainum, w_s_p;
    logic                    w_dneg;
    logic [RW-1:0]           w_sat;
    logic [KW-1:0]           w_cmag, w_csgn;
    logic signed [DW-1:0]    w_n, w_sx, w_sy, w_sxx, w_syy, w_sxy;

    // register the sample products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_px  <= i_x;
            r_py  <= i_y;
            r_pxx <= i_x * i_x;
            r_pyy <= i_y * i_y;
            r_pxy <= i_x * i_y;
        end
    end

    // accumulate until the set is full, clear after a fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.acc_clr) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (r_p_vld && r_cnt < CW'(MAX_PAIRS)) begin
            r_cnt <= r_cnt + 1'b1;
            r_sx  <= r_sx + {{(SW1-SB){r_px[SB-1]}}, r_px};
            r_sy  <= r_sy + {{(SW1-SB){r_py[SB-1]}}, r_py};
            r_sxx <= r_sxx + {{(SW2-2*SB){r_pxx[2*SB-1]}}, r_pxx};
            r_syy <= r_syy + {{(SW2-2*SB){r_pyy[2*SB-1]}}, r_pyy};
            r_sxy <= r_sxy + {{(SW2-2*SB){r_pxy[2*SB-1]}}, r_pxy};
        end
    end

    // widen the sums to operand width
    assign w_n   = $signed({{(DW-CW){1'b0}}, r_cnt});
    assign w_sx  = {{(DW-SW1){r_sx[SW1-1]}}, r_sx};
    assign w_sy  = {{(DW-SW1){r_sy[SW1-1]}}, r_sy};
    assign w_sxx = {{(DW-SW2){r_sxx[SW2-1]}}, r_sxx};
    assign w_syy = {{(DW-SW2){r_syy[SW2-1]}}, r_syy};
    assign w_sxy = {{(DW-SW2){r_sxy[SW2-1]}}, r_sxy};

    // select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_op)
            lrf_pkg::MUL_NXX:    begin w_ma = w_n;   w_mb = w_sxx; end
            lrf_pkg::MUL_XX:     begin w_ma = w_sx;  w_mb = w_sx;  end
            lrf_pkg::MUL_NYY:    begin w_ma = w_n;   w_mb = w_syy; end
            lrf_pkg::MUL_YY:     begin w_ma = w_sy;  w_mb = w_sy;  end
            lrf_pkg::MUL_NXY:    begin w_ma = w_n;   w_mb = w_sxy; end
            lrf_pkg::MUL_XY:     begin w_ma = w_sx;  w_mb = w_sy;  end
            lrf_pkg::MUL_YDXX:   begin w_ma = w_sy;  w_mb = r_dxx; end
            lrf_pkg::MUL_DXYX:   begin w_ma = r_dxy; w_mb = w_sx;  end
            lrf_pkg::MUL_NDXX:   begin w_ma = w_n;   w_mb = r_dxx; end
            lrf_pkg::MUL_DXXDYY: begin w_ma = r_dxx; w_mb = r_dyy; end
            default:             begin w_ma = '0;    w_mb = '0;    end
        endcase
    end

    lrf_mul #(.DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_p)
    );

    // store products into the fit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_wr) begin
            unique case (i_cmd.mul_op)
                lrf_pkg::MUL_NXX:    r_dxx  <= w_p[DW-1:0];
                lrf_pkg::MUL_XX:     r_dxx  <= r_dxx - w_p[DW-1:0];
                lrf_pkg::MUL_NYY:    r_dyy  <= w_p[DW-1:0];
                lrf_pkg::MUL_YY:     r_dyy  <= r_dyy - w_p[DW-1:0];
                lrf_pkg::MUL_NXY:    r_dxy  <= w_p[DW-1:0];
                lrf_pkg::MUL_XY:     r_dxy  <= r_dxy - w_p[DW-1:0];
                lrf_pkg::MUL_YDXX:   r_inum <= w_p;
                lrf_pkg::MUL_DXYX:   r_inum <= r_inum - w_p;
                lrf_pkg::MUL_NDXX:   r_den  <= w_p;
                lrf_pkg::MUL_DXXDYY: r_prod <= w_p;
                default:             r_prod <= r_prod;
            endcase
        end
    end

    // magnitudes for the rounded divisions
    assign w_adxy   = r_dxy[DW-1] ? DW'(~r_dxy + 1'b1) : DW'(r_dxy);
    assign w_adxy_p = {{(PW-DW){1'b0}}, w_adxy};
    assign w_ainum  = r_inum[PW-1] ? PW'(~r_inum + 1'b1) : PW'(r_inum);
    assign w_s_p    = {{(PW-DW){1'b0}}, r_s};

    // round half away: (2|a|*k + b) / 2b, k the scale of the result format
    always_comb begin
        unique case (i_cmd.div_op)
            lrf_pkg::DIV_SLOPE: begin
                w_dnum = (w_adxy_p << 17) + {{(PW-DW){1'b0}}, r_dxx};
                w_dden = {{(PW-DW){1'b0}}, r_dxx} << 1;
                w_dneg = r_dxy[DW-1];
            end
            lrf_pkg::DIV_ICPT: begin
                w_dnum = (w_ainum << 9) + r_den;
                w_dden = r_den << 1;
                w_dneg = r_inum[PW-1];
            end
            lrf_pkg::DIV_CORR: begin
                w_dnum = (w_adxy_p << (lrf_pkg::CORR_FRAC + 1)) + w_s_p;
                w_dden = w_s_p << 1;
                w_dneg = r_dxy[DW-1];
            end
            default: begin
                w_dnum = '0;
                w_dden = '0;
                w_dneg = 1'b0;
            end
        endcase
    end

    lrf_div #(.PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    lrf_sqrt #(.PW(PW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     (r_prod),
        .o_done  (w_sdone),
        .o_root  (w_root)
    );

    // saturate and sign the quotient
    always_comb begin
        if (!w_dneg) begin
            w_sat = (w_q > {{(PW-RW){1'b0}}, POS_MAX}) ? POS_MAX : w_q[RW-1:0];
        end else begin
            w_sat = (w_q > {{(PW-RW){1'b0}}, NEG_MAX}) ? NEG_MAX : RW'(~w_q[RW-1:0] + 1'b1);
        end
        w_cmag = (w_q > {{(PW-KW){1'b0}}, CORR_ONE}) ? CORR_ONE : w_q[KW-1:0];
        w_csgn = w_dneg ? KW'(~w_cmag + 1'b1) : w_cmag;
    end

    // update fit results
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_slope <= '0;
            r_icpt  <= '0;
            r_corr  <= '0;
            r_stat  <= lrf_pkg::FIT_OK;
        end else begin
            if (i_cmd.div_wr) begin
                unique case (i_cmd.div_op)
                    lrf_pkg::DIV_SLOPE: r_slope <= w_sat;
                    lrf_pkg::DIV_ICPT:  r_icpt  <= w_sat;
                    lrf_pkg::DIV_CORR:  r_corr  <= w_csgn;
                    default:            r_corr  <= r_corr;
                endcase
            end
            if (i_cmd.stat_wr) begin
                r_stat <= i_cmd.stat_code;
            end
        end
        if (i_cmd.sqrt_wr) begin
            r_s <= w_root;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_slope <= r_slope;
            r_o_icpt  <= r_icpt;
            r_o_corr  <= r_corr;
            r_o_count <= r_cnt;
            r_o_stat  <= r_stat;
        end
    end

    always_comb begin
        o_status.mul_done  = w_mdone;
        o_status.div_done  = w_ddone;
        o_status.sqrt_done = w_sdone;
        o_status.n_zero    = (r_cnt == '0);
        o_status.dxx_zero  = (r_dxx == '0);
        o_status.dyy_zero  = (r_dyy == '0);
        o_status.s_zero    = (r_s == '0);
        o_status.out_full  = r_ovld && !i_out_ready;
    end

    assign o_out_valid = r_ovld;
    assign o_slope     = $signed(r_o_slope);
    assign o_icpt      = $signed(r_o_icpt);
    assign o_corr      = $signed(r_o_corr);
    assign o_count     = r_o_count;
    assign o_stat      = r_o_stat;
endmodule

// ===== hdl/lrf_ctrl.sv =====
// Controller: accumulation phase and the sequence of fit steps.
module lrf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_last,
    input  lrf_pkg::t_status i_status,
    output logic             o_in_ready,
    output lrf_pkg::t_cmd    o_cmd
);
    lrf_pkg::t_state  r_state, n_state;
    lrf_pkg::t_mul_op r_mop, n_mop;
    lrf_pkg::t_div_op r_dop, n_dop;

    // hold state and step codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrf_pkg::ST_ACC;
            r_mop   <= lrf_pkg::MUL_NXX;
            r_dop   <= lrf_pkg::DIV_SLOPE;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_dop   <= n_dop;
        end
    end

    // advance through the fit
    always_comb begin
        n_state         = r_state;
        n_mop           = r_mop;
        n_dop           = r_dop;
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.mul_op    = r_mop;
        o_cmd.div_op    = r_dop;
        o_cmd.stat_code = lrf_pkg::FIT_OK;
        unique case (r_state)
            lrf_pkg::ST_ACC: begin
                o_in_ready = 1'b1;
                if (i_accept && i_last) begin
                    n_state = lrf_pkg::ST_DRAIN;
                end
            end
            lrf_pkg::ST_DRAIN: begin
                o_cmd.res_clr = 1'b1;
                n_mop         = lrf_pkg::MUL_NXX;
                n_state       = lrf_pkg::ST_MUL;
            end
            lrf_pkg::ST_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = lrf_pkg::ST_MUL_W;
            end
            lrf_pkg::ST_MUL_W: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_wr = 1'b1;
                    if (r_mop == lrf_pkg::MUL_XY) begin
                        n_state = lrf_pkg::ST_CHECK;
                    end else if (r_mop == lrf_pkg::MUL_DXXDYY) begin
                        n_dop   = lrf_pkg::DIV_SLOPE;
                        n_state = lrf_pkg::ST_DIV;
                    end else begin
                        n_mop   = lrf_pkg::t_mul_op'(r_mop + 4'd1);
                        n_state = lrf_pkg::ST_MUL;
                    end
                end
            end
            lrf_pkg::ST_CHECK: begin
                if (i_status.n_zero) begin
                    o_cmd.stat_wr   = 1'b1;
                    o_cmd.stat_code = lrf_pkg::FIT_EMPTY;
                    n_state         = lrf_pkg::ST_OUT;
                end else if (i_status.dxx_zero) begin
                    o_cmd.stat_wr   = 1'b1;
                    o_cmd.stat_code = lrf_pkg::FIT_XVAR0;
                    n_state         = lrf_pkg::ST_OUT;
                end else begin
                    n_mop   = lrf_pkg::MUL_YDXX;
                    n_state = lrf_pkg::ST_MUL;
                end
            end
            lrf_pkg::ST_DIV: begin
                // a zero root leaves the correlation at zero
                if (r_dop == lrf_pkg::DIV_CORR && i_status.s_zero) begin
                    n_state = lrf_pkg::ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = lrf_pkg::ST_DIV_W;
                end
            end
            lrf_pkg::ST_DIV_W: begin
                if (i_status.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    unique case (r_dop)
                        lrf_pkg::DIV_SLOPE: begin
                            n_dop   = lrf_pkg::DIV_ICPT;
                            n_state = lrf_pkg::ST_DIV;
                        end
                        lrf_pkg::DIV_ICPT: begin
                            if (i_status.dyy_zero) begin
                                o_cmd.stat_wr   = 1'b1;
                                o_cmd.stat_code = lrf_pkg::FIT_YVAR0;
                                n_state         = lrf_pkg::ST_OUT;
                            end else begin
                                n_state = lrf_pkg::ST_SQRT;
                            end
                        end
                        default: begin
                            n_state = lrf_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            lrf_pkg::ST_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = lrf_pkg::ST_SQRT_W;
            end
            lrf_pkg::ST_SQRT_W: begin
                if (i_status.sqrt_done) begin
                    o_cmd.sqrt_wr = 1'b1;
                    n_dop         = lrf_pkg::DIV_CORR;
                    n_state       = lrf_pkg::ST_DIV;
                end
            end
            lrf_pkg::ST_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.acc_clr  = 1'b1;
                    n_state        = lrf_pkg::ST_ACC;
                end
            end
            default: begin
                n_state = lrf_pkg::ST_ACC;
            end
        endcase
    end
endmodule

// ===== hdl/linear_regression_fit.sv =====
// Top level of the least-squares line fit with correlation.
//
//  channel  | dir | request payload
//  ---------+-----+-------------------------------------------------------
//  i_in     | in  | x_sample, y_sample (signed Q8.8), last_pair
//  o_out    | out | slope, intercept (Q16.16), correlation (Q1.14),
//           |     | pair_count, fit_status
//
// Pairs are taken one per cycle while a set accumulates, then input is held off.
// After the last pair the fit runs up to ten DW-bit products, three 2*DW-bit quotients
// and a square root of a 2*DW-bit value before the result comes; DW = 2*SAMPLE_BITS + 2*CW,
// CW = ceil(log2(MAX_PAIRS+1)). Reset is synchronous, active low, and clears the sums.
// A waiting result stalls the next fit at its end until the output register is free.
`include "assert_macros.svh"

module linear_regression_fit #(
    parameter int MAX_PAIRS   = lrf_pkg::MAX_PAIRS_DEF,
    parameter int SAMPLE_BITS = lrf_pkg::SAMPLE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lrf_in_if.sink   i_in,
    lrf_out_if.source o_out
);
    lrf_pkg::t_cmd    w_cmd;
    lrf_pkg::t_status w_status;
    logic             w_in_ready;
    logic             w_accept;
    logic [2:0]       w_starts;

    // accept a pair request
    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    lrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_last     (i_in.last_pair),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lrf_dp #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_x         (i_in.x_sample),
        .i_y         (i_in.y_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_slope     (o_out.slope),
        .o_icpt      (o_out.intercept),
        .o_corr      (o_out.correlation),
        .o_count     (o_out.pair_count),
        .o_stat      (o_out.fit_status)
    );

    assign w_starts = {w_cmd.mul_start, w_cmd.div_start, w_cmd.sqrt_start};

    // only one arithmetic unit is launched at a time
    `LRF_ASSERT(a_one_start, $onehot0(w_starts), "two units started")
    // a new result never overwrites one still waiting
    `LRF_ASSERT_IMP(a_load_free, w_cmd.out_load, !(o_out.valid && !o_out.ready), "result overwritten")
    // products and quotients are stored only when their unit has finished
    `LRF_ASSERT_IMP(a_mul_wr, w_cmd.mul_wr, w_status.mul_done, "product stored early")
    `LRF_ASSERT_IMP(a_div_wr, w_cmd.div_wr, w_status.div_done, "quotient stored early")
endmodule
